FILE: rtl/random_fourier_feature_eval_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the random Fourier feature evaluator
// Concurrent checks on clk with rst_n as the disable; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef RANDOM_FOURIER_FEATURE_EVAL_UNIT_MACROS_SVH
`define RANDOM_FOURIER_FEATURE_EVAL_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define RFFE_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rffe assertion failed: same-cycle implication");
// next-cycle implication
`define RFFE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rffe assertion failed: next-cycle implication");
`else
`define RFFE_ASSERT_IMPLIES(label, ante, cons)
`define RFFE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/rffe_pkg.sv
// ----------------------------------------------------------------------------
// rffe_pkg
// Shared types, constants and arithmetic helpers of the feature evaluator.
// ----------------------------------------------------------------------------
package rffe_pkg;

    localparam int MAX_ENTRIES_DEF = 64;

    // cordic datapath
    localparam int CORDIC_STEPS = 16;
    localparam int XW           = 34;
    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032876;
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20861
    };

    // 2pi in Q.29
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

    // sideband through the cordic chain: flip, direction, weight, omega
    localparam int OMW = 35;
    localparam int SBW = 1 + 54 + 16 + OMW;

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    // configuration register indexes
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_ACTIVE_ENTRIES = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_NORM_SCALE     = 2'd1;

    // one basis entry
    typedef struct packed {
        logic signed [17:0] dz;
        logic signed [17:0] dy;
        logic signed [17:0] dx;
        logic [31:0]        freq;
        logic [15:0]        phase;
        logic signed [15:0] weight;
    } ent_t;

    // control from the sequencer to the datapath
    typedef struct packed {
        logic wr_en;
        logic clear;
        logic issue;
    } ctl_t;

    // acc * scale >> 15, floor
    function automatic logic signed [65:0] scale_sum(input logic signed [63:0] acc,
                                                     input logic [15:0] scale);
        logic signed [48:0] hi;
        logic [30:0]        lon;
        hi  = 49'(acc >>> 15);
        lon = 31'(acc[14:0]) * 31'(scale);
        // widen before the multiply so the high part cannot wrap
        return 66'(hi) * 66'($signed({1'b0, scale})) + $signed(66'(lon[30:15]));
    endfunction

    function automatic logic [47:0] sat_s48(input logic signed [65:0] v);
        logic signed [65:0] hi_lim;
        logic signed [65:0] lo_lim;
        hi_lim = 66'sd140737488355327;
        lo_lim = -66'sd140737488355328;
        if (v > hi_lim) return hi_lim[47:0];
        else if (v < lo_lim) return lo_lim[47:0];
        else return v[47:0];
    endfunction

    function automatic logic [47:0] sat_u48(input logic signed [65:0] v);
        if (v < 66'sd0) return 48'd0;
        else if (v > 66'sd281474976710655) return {48{1'b1}};
        else return v[47:0];
    endfunction

endpackage

FILE: rtl/rffe_if.sv
// ----------------------------------------------------------------------------
// rffe channel interfaces
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------
interface rffe_item_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [5:0]         entry_index;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] dir_z;
    logic [31:0]        frequency;
    logic [15:0]        phase;
    logic signed [15:0] weight;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, kind, entry_index, dir_x, dir_y, dir_z, frequency,
                    phase, weight, point_x, point_y, point_z, input ready);
    modport sink (input valid, kind, entry_index, dir_x, dir_y, dir_z, frequency,
                  phase, weight, point_x, point_y, point_z, output ready);
endinterface

interface rffe_result_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] field_value;
    logic signed [47:0] gradient_x;
    logic signed [47:0] gradient_y;
    logic signed [47:0] gradient_z;
    logic [47:0]        lipschitz_bound;

    modport source (output valid, field_value, gradient_x, gradient_y, gradient_z,
                    lipschitz_bound, input ready);
    modport sink (input valid, field_value, gradient_x, gradient_y, gradient_z,
                  lipschitz_bound, output ready);
endinterface

interface rffe_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/rffe_cordic_cell.sv
// ----------------------------------------------------------------------------
// rffe_cordic_cell
// One rotation step of the turn-unit cordic, registered, with a sideband.
// ----------------------------------------------------------------------------
module rffe_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           up_valid,
    input  logic signed [rffe_pkg::XW-1:0] up_x,
    input  logic signed [rffe_pkg::XW-1:0] up_y,
    input  logic signed [rffe_pkg::XW-1:0] up_z,
    input  logic [rffe_pkg::SBW-1:0]       up_sb,
    output logic                           valid,
    output logic signed [rffe_pkg::XW-1:0] x,
    output logic signed [rffe_pkg::XW-1:0] y,
    output logic signed [rffe_pkg::XW-1:0] z,
    output logic [rffe_pkg::SBW-1:0]       sb
);
    import rffe_pkg::*;

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [XW-1:0] ang;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    logic signed [XW-1:0] z_next;
    logic                 valid_reg;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic signed [XW-1:0] z_reg;
    logic [SBW-1:0]       sb_reg;

    // rotate toward zero residual angle
    always_comb
    begin
        dx  = up_y >>> IDX;
        dy  = up_x >>> IDX;
        ang = $signed(XW'(ATAN_TURNS[IDX]));
        if (!up_z[XW-1])
        begin
            x_next = up_x - dx;
            y_next = up_y + dy;
            z_next = up_z - ang;
        end
        else
        begin
            x_next = up_x + dx;
            y_next = up_y - dy;
            z_next = up_z + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= x_next;
        y_reg  <= y_next;
        z_reg  <= z_next;
        sb_reg <= up_sb;
    end

    assign valid = valid_reg;
    assign x     = x_reg;
    assign y     = y_reg;
    assign z     = z_reg;
    assign sb    = sb_reg;

endmodule

FILE: rtl/rffe_datapath.sv
// ----------------------------------------------------------------------------
// rffe_datapath
// Basis table, per-entry pipeline around the cordic chain, and accumulators.
// ----------------------------------------------------------------------------
module rffe_datapath #(
    parameter int MAX_ENTRIES = rffe_pkg::MAX_ENTRIES_DEF,
    parameter int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rffe_pkg::ctl_t       ctl,
    input  logic [AW-1:0]        rd_addr,
    input  logic [AW-1:0]        wr_addr,
    input  rffe_pkg::ent_t       wr_entry,
    input  logic signed [31:0]   pt_x,
    input  logic signed [31:0]   pt_y,
    input  logic signed [31:0]   pt_z,
    output logic                 busy,
    output logic signed [63:0]   acc_v,
    output logic signed [63:0]   acc_gx,
    output logic signed [63:0]   acc_gy,
    output logic signed [63:0]   acc_gz,
    output logic [63:0]          acc_l
);
    import rffe_pkg::*;

    localparam int NC = CORDIC_STEPS;

    // basis table
    ent_t mem [MAX_ENTRIES];
    ent_t rd_reg;
    logic v0_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (ctl.issue)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // stage 1: direction products and omega
    logic signed [49:0] prod_x;
    logic signed [49:0] prod_y;
    logic signed [49:0] prod_z;
    logic [63:0]        om_full;
    logic               p1_v_reg;
    logic signed [49:0] p1_px_reg;
    logic signed [49:0] p1_py_reg;
    logic signed [49:0] p1_pz_reg;
    ent_t               p1_ent_reg;
    logic [OMW-1:0]     p1_om_reg;

    assign prod_x  = 50'(rd_reg.dx) * 50'(pt_x);
    assign prod_y  = 50'(rd_reg.dy) * 50'(pt_y);
    assign prod_z  = 50'(rd_reg.dz) * 50'(pt_z);
    assign om_full = 64'(rd_reg.freq) * 64'(TWO_PI_Q29);

    always_ff @(posedge clk)
    begin
        p1_px_reg  <= prod_x;
        p1_py_reg  <= prod_y;
        p1_pz_reg  <= prod_z;
        p1_ent_reg <= rd_reg;
        p1_om_reg  <= om_full[63:29];
    end

    // stage 2: dot product
    logic signed [51:0] p2_dot_reg;
    logic               p2_v_reg;
    ent_t               p2_ent_reg;
    logic [OMW-1:0]     p2_om_reg;

    always_ff @(posedge clk)
    begin
        p2_dot_reg <= 52'(p1_px_reg) + 52'(p1_py_reg) + 52'(p1_pz_reg);
        p2_ent_reg <= p1_ent_reg;
        p2_om_reg  <= p1_om_reg;
    end

    // stage 3: dot times frequency as two partial products
    logic signed [55:0] d56;
    logic [59:0]        mul_lo;
    logic [59:0]        mul_hi;
    logic               p3_v_reg;
    logic [59:0]        p3_lo_reg;
    logic [27:0]        p3_hi_reg;
    ent_t               p3_ent_reg;
    logic [OMW-1:0]     p3_om_reg;

    assign d56    = 56'(p2_dot_reg);
    assign mul_lo = 60'(d56[27:0]) * 60'(p2_ent_reg.freq);
    assign mul_hi = 60'(d56[55:28]) * 60'(p2_ent_reg.freq);

    always_ff @(posedge clk)
    begin
        p3_lo_reg  <= mul_lo;
        p3_hi_reg  <= mul_hi[27:0];
        p3_ent_reg <= p2_ent_reg;
        p3_om_reg  <= p2_om_reg;
    end

    // stage 4: angle in turns plus phase
    logic [55:0]    sum56;
    logic [31:0]    p4_angle_reg;
    logic           p4_v_reg;
    ent_t           p4_ent_reg;
    logic [OMW-1:0] p4_om_reg;

    assign sum56 = p3_lo_reg[55:0] + {p3_hi_reg, 28'd0};

    always_ff @(posedge clk)
    begin
        p4_angle_reg <= sum56[55:24] + {p3_ent_reg.phase, 16'd0};
        p4_ent_reg   <= p3_ent_reg;
        p4_om_reg    <= p3_om_reg;
    end

    // fold the angle into the right half-plane and seed the chain
    logic [31:0]          ang_plus;
    logic                 flip;
    logic [31:0]          ang_fold;
    logic [NC:0]          c_v;
    logic signed [XW-1:0] c_x [NC+1];
    logic signed [XW-1:0] c_y [NC+1];
    logic signed [XW-1:0] c_z [NC+1];
    logic [SBW-1:0]       c_sb [NC+1];

    assign ang_plus = p4_angle_reg + 32'h4000_0000;
    assign flip     = ang_plus[31];
    assign ang_fold = {p4_angle_reg[31] ^ flip, p4_angle_reg[30:0]};
    assign c_v[0]   = p4_v_reg;
    assign c_x[0]   = CORDIC_GAIN;
    assign c_y[0]   = '0;
    assign c_z[0]   = XW'($signed(ang_fold));
    assign c_sb[0]  = {flip, p4_ent_reg.dz, p4_ent_reg.dy, p4_ent_reg.dx,
                       p4_ent_reg.weight, p4_om_reg};

    // cordic chain
    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        rffe_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (c_v[i]),
            .up_x     (c_x[i]),
            .up_y     (c_y[i]),
            .up_z     (c_z[i]),
            .up_sb    (c_sb[i]),
            .valid    (c_v[i+1]),
            .x        (c_x[i+1]),
            .y        (c_y[i+1]),
            .z        (c_z[i+1]),
            .sb       (c_sb[i+1])
        );
    end

    // stage 6: weighted cos and sin, lipschitz term
    logic                 t_flip;
    logic [53:0]          t_dir;
    logic signed [15:0]   t_w;
    logic [OMW-1:0]       t_om;
    logic signed [XW-1:0] cos_v;
    logic signed [XW-1:0] sin_v;
    logic signed [49:0]   vt_full;
    logic signed [49:0]   ws_full;
    logic [15:0]          abs_w;
    logic [50:0]          lt_full;
    logic                 p6_v_reg;
    logic signed [39:0]   p6_vt_reg;
    logic signed [27:0]   p6_ws_reg;
    logic [47:0]          p6_lt_reg;
    logic [53:0]          p6_dir_reg;
    logic [OMW-1:0]       p6_om_reg;

    assign {t_flip, t_dir, t_w, t_om} = c_sb[NC];
    assign cos_v   = t_flip ? -c_x[NC] : c_x[NC];
    assign sin_v   = t_flip ? -c_y[NC] : c_y[NC];
    assign vt_full = 50'(t_w) * 50'(cos_v);
    assign ws_full = 50'(t_w) * 50'(sin_v);
    assign abs_w   = t_w[15] ? 16'(-t_w) : 16'(t_w);
    assign lt_full = 51'(abs_w) * 51'(t_om);

    always_ff @(posedge clk)
    begin
        p6_vt_reg  <= 40'(vt_full >>> 10);
        p6_ws_reg  <= 28'(ws_full >>> 22);
        p6_lt_reg  <= 48'(lt_full >> 4);
        p6_dir_reg <= t_dir;
        p6_om_reg  <= t_om;
    end

    // stage 7: scale sine term by omega
    logic signed [63:0] wo_full;
    logic               p7_v_reg;
    logic signed [39:0] p7_wo_reg;
    logic signed [39:0] p7_vt_reg;
    logic [47:0]        p7_lt_reg;
    logic [53:0]        p7_dir_reg;

    assign wo_full = 64'(p6_ws_reg) * 64'($signed({1'b0, p6_om_reg}));

    always_ff @(posedge clk)
    begin
        p7_wo_reg  <= 40'(wo_full >>> 24);
        p7_vt_reg  <= p6_vt_reg;
        p7_lt_reg  <= p6_lt_reg;
        p7_dir_reg <= p6_dir_reg;
    end

    // stage 8: gradient terms along the direction
    logic signed [17:0] g_dx;
    logic signed [17:0] g_dy;
    logic signed [17:0] g_dz;
    logic signed [57:0] gp_x;
    logic signed [57:0] gp_y;
    logic signed [57:0] gp_z;
    logic signed [57:0] gs_x;
    logic signed [57:0] gs_y;
    logic signed [57:0] gs_z;
    logic               p8_v_reg;
    logic signed [54:0] p8_gx_reg;
    logic signed [54:0] p8_gy_reg;
    logic signed [54:0] p8_gz_reg;
    logic signed [39:0] p8_vt_reg;
    logic [47:0]        p8_lt_reg;

    assign {g_dz, g_dy, g_dx} = p7_dir_reg;
    assign gp_x = 58'(p7_wo_reg) * 58'(g_dx);
    assign gp_y = 58'(p7_wo_reg) * 58'(g_dy);
    assign gp_z = 58'(p7_wo_reg) * 58'(g_dz);
    assign gs_x = gp_x >>> 4;
    assign gs_y = gp_y >>> 4;
    assign gs_z = gp_z >>> 4;

    always_ff @(posedge clk)
    begin
        p8_gx_reg <= 55'(-gs_x);
        p8_gy_reg <= 55'(-gs_y);
        p8_gz_reg <= 55'(-gs_z);
        p8_vt_reg <= p7_vt_reg;
        p8_lt_reg <= p7_lt_reg;
    end

    // accumulators
    logic signed [63:0] acc_v_reg;
    logic signed [63:0] acc_gx_reg;
    logic signed [63:0] acc_gy_reg;
    logic signed [63:0] acc_gz_reg;
    logic [63:0]        acc_l_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            acc_v_reg  <= '0;
            acc_gx_reg <= '0;
            acc_gy_reg <= '0;
            acc_gz_reg <= '0;
            acc_l_reg  <= '0;
        end
        else if (p8_v_reg)
        begin
            acc_v_reg  <= acc_v_reg + 64'(p8_vt_reg);
            acc_gx_reg <= acc_gx_reg + 64'(p8_gx_reg);
            acc_gy_reg <= acc_gy_reg + 64'(p8_gy_reg);
            acc_gz_reg <= acc_gz_reg + 64'(p8_gz_reg);
            acc_l_reg  <= acc_l_reg + 64'(p8_lt_reg);
        end
    end

    // valid bits along the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
            p6_v_reg <= 1'b0;
            p7_v_reg <= 1'b0;
            p8_v_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= ctl.issue;
            p1_v_reg <= v0_reg;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            p6_v_reg <= c_v[NC];
            p7_v_reg <= p6_v_reg;
            p8_v_reg <= p7_v_reg;
        end
    end

    assign busy   = v0_reg | p1_v_reg | p2_v_reg | p3_v_reg | (|c_v)
                  | p6_v_reg | p7_v_reg | p8_v_reg;
    assign acc_v  = acc_v_reg;
    assign acc_gx = acc_gx_reg;
    assign acc_gy = acc_gy_reg;
    assign acc_gz = acc_gz_reg;
    assign acc_l  = acc_l_reg;

endmodule

FILE: rtl/random_fourier_feature_eval_unit.sv
// ----------------------------------------------------------------------------
// random_fourier_feature_eval_unit
// Sums weighted cosine features, their gradient and a Lipschitz bound.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready channel. kind 0 writes one basis entry into the table;
//            kind 1 evaluates a point and gives one result.
//   result : valid/ready channel with value, gradient and Lipschitz bound.
//   cfg    : write channel, always ready; index 0 is active_entries, index 1
//            is norm_scale. Write only while no evaluation is in progress.
//   An evaluation walks the n active entries from the accepted transaction:
//   one entry enters the shared dot-product / cordic / accumulate pipe per
//   cycle, and the pipe, a 16-cell cordic chain plus table read and multiply
//   stages, must drain before the sums are scaled and saturated. An empty
//   table skips the walk.
//   Items are taken one evaluation at a time; a new item is accepted while a
//   finished result still waits in the output register.
//   If the receiver stalls, the result holds and the next evaluation waits
//   at its final step until the output register is free.
//   Reset clears both registers and the control; table contents stay
//   undefined until written.
// ----------------------------------------------------------------------------
`include "random_fourier_feature_eval_unit_macros.svh"

module random_fourier_feature_eval_unit #(
    parameter int MAX_ENTRIES = rffe_pkg::MAX_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    rffe_item_if.sink     item,
    rffe_result_if.source result,
    rffe_cfg_if.sink      cfg
);
    import rffe_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RUN   = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_SCALE = 5'b01000,
        ST_SAT   = 5'b10000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [6:0]         active_reg;
    logic [15:0]        norm_reg;
    logic [6:0]         n_eff;
    logic [6:0]         n_reg;
    logic [6:0]         cnt_reg;
    logic               item_acc;
    logic               out_load;
    logic               out_valid_reg;
    logic               pipe_busy;
    ctl_t               ctl;
    ent_t               wr_entry;
    logic signed [31:0] pt_x_reg;
    logic signed [31:0] pt_y_reg;
    logic signed [31:0] pt_z_reg;
    logic signed [63:0] acc_v;
    logic signed [63:0] acc_gx;
    logic signed [63:0] acc_gy;
    logic signed [63:0] acc_gz;
    logic [63:0]        acc_l;
    logic signed [65:0] sc_v_reg;
    logic signed [65:0] sc_gx_reg;
    logic signed [65:0] sc_gy_reg;
    logic signed [65:0] sc_gz_reg;
    logic signed [65:0] sc_l_reg;
    logic [47:0]        fv_reg;
    logic [47:0]        gx_reg;
    logic [47:0]        gy_reg;
    logic [47:0]        gz_reg;
    logic [47:0]        lb_reg;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            norm_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ACTIVE_ENTRIES: active_reg <= cfg.data[6:0];
                CFG_NORM_SCALE:     norm_reg   <= cfg.data;
                default:            ;
            endcase
        end
    end

    // input side
    assign item.ready = (state_reg == ST_IDLE);
    assign item_acc   = item.valid & item.ready;
    assign n_eff      = (int'(active_reg) > MAX_ENTRIES) ? 7'(MAX_ENTRIES) : active_reg;

    assign ctl.wr_en = item_acc && (item.kind == KIND_WRITE)
                     && (int'(item.entry_index) < MAX_ENTRIES);
    assign ctl.clear = item_acc && (item.kind == KIND_EVAL);
    assign ctl.issue = (state_reg == ST_RUN);

    assign wr_entry.dx     = item.dir_x;
    assign wr_entry.dy     = item.dir_y;
    assign wr_entry.dz     = item.dir_z;
    assign wr_entry.freq   = item.frequency;
    assign wr_entry.phase  = item.phase;
    assign wr_entry.weight = item.weight;

    // sequencer
    assign out_load = (state_reg == ST_SAT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.clear)
                begin
                    state_next = (n_eff == '0) ? ST_SCALE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == 7'(n_reg - 7'd1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: state_next = ST_SAT;
            ST_SAT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.clear)
            begin
                n_reg   <= n_eff;
                cnt_reg <= '0;
            end
            else if (ctl.issue)
            begin
                cnt_reg <= cnt_reg + 7'd1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // point held for the whole walk
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            pt_x_reg <= item.point_x;
            pt_y_reg <= item.point_y;
            pt_z_reg <= item.point_z;
        end
    end

    rffe_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .rd_addr  (AW'(cnt_reg)),
        .wr_addr  (AW'(item.entry_index)),
        .wr_entry (wr_entry),
        .pt_x     (pt_x_reg),
        .pt_y     (pt_y_reg),
        .pt_z     (pt_z_reg),
        .busy     (pipe_busy),
        .acc_v    (acc_v),
        .acc_gx   (acc_gx),
        .acc_gy   (acc_gy),
        .acc_gz   (acc_gz),
        .acc_l    (acc_l)
    );

    // normalization
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCALE)
        begin
            sc_v_reg  <= scale_sum(acc_v, norm_reg);
            sc_gx_reg <= scale_sum(acc_gx, norm_reg);
            sc_gy_reg <= scale_sum(acc_gy, norm_reg);
            sc_gz_reg <= scale_sum(acc_gz, norm_reg);
            sc_l_reg  <= scale_sum($signed(acc_l), norm_reg);
        end
    end

    // saturation into the output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            fv_reg <= sat_s48(sc_v_reg);
            gx_reg <= sat_s48(sc_gx_reg);
            gy_reg <= sat_s48(sc_gy_reg);
            gz_reg <= sat_s48(sc_gz_reg);
            lb_reg <= sat_u48(sc_l_reg);
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.field_value     = $signed(fv_reg);
    assign result.gradient_x      = $signed(gx_reg);
    assign result.gradient_y      = $signed(gy_reg);
    assign result.gradient_z      = $signed(gz_reg);
    assign result.lipschitz_bound = lb_reg;

    // checks
    `RFFE_ASSERT_NEXT(a_empty_skips_walk, ctl.clear && (n_eff == '0), state_reg == ST_SCALE)
    `RFFE_ASSERT_IMPLIES(a_idle_pipe_empty, state_reg == ST_IDLE, !pipe_busy)
    `RFFE_ASSERT_NEXT(a_load_shows_result, out_load, result.valid)
    `RFFE_ASSERT_IMPLIES(a_issue_in_range, ctl.issue, cnt_reg < n_reg)

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives basis table writes and point evaluations into the random Fourier
// feature evaluator, predicts each result in fixed point and compares fields.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rffe_pkg::*;

    typedef struct {
        logic signed [47:0] value;
        logic signed [47:0] gx;
        logic signed [47:0] gy;
        logic signed [47:0] gz;
        logic [47:0]        lip;
    } field_result_t;

    typedef struct {
        logic               kind;
        logic [5:0]         idx;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic signed [17:0] dz;
        logic [31:0]        freq;
        logic [15:0]        phase;
        logic signed [15:0] weight;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } basis_item_t;

    localparam int MAX_ENT = 64;
    localparam int DRAIN_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rffe_item_if   item_ch();
    rffe_result_if result_ch();
    rffe_cfg_if    cfg_ch();

    random_fourier_feature_eval_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // predictor state
    logic signed [17:0] tbl_dx [MAX_ENT];
    logic signed [17:0] tbl_dy [MAX_ENT];
    logic signed [17:0] tbl_dz [MAX_ENT];
    logic [31:0]        tbl_freq [MAX_ENT];
    logic [15:0]        tbl_phase [MAX_ENT];
    logic signed [15:0] tbl_weight [MAX_ENT];
    bit                 tbl_written [MAX_ENT];
    int unsigned        cur_active;
    logic [15:0]        cur_scale;

    field_result_t expected_fields [$];
    int  error_count = 0;
    bit  hold_off = 1'b0;
    bit  long_hold = 1'b0;

    // clock
    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #200ms;
        $display("random_fourier_feature_eval_unit verification failed");
        $finish;
    end

    // floor shift of a signed value
    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic void cordic_turns(input logic [31:0] ang,
                                         output longint c, output longint s);
        longint x, y, z, dxs, dys;
        bit     flip;
        logic [31:0] a;
        a = ang;
        flip = ((a + 32'h4000_0000) & 32'h8000_0000) != 0;
        if (flip)
            a = a ^ 32'h8000_0000;
        x = 652032876;
        y = 0;
        z = longint'($signed(a));
        for (int i = 0; i < 16; i++)
        begin
            dxs = y >>> i;
            dys = x >>> i;
            if (z >= 0)
            begin
                x -= dxs; y += dys; z -= longint'(ATAN_TURNS[i]);
            end
            else
            begin
                x += dxs; y -= dys; z += longint'(ATAN_TURNS[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // sum * scale >> 15 (floor), wide enough not to overflow
    function automatic logic signed [95:0] apply_scale(input longint acc);
        logic signed [95:0] wide;
        wide = 96'(acc) * $signed({80'd0, cur_scale});
        return wide >>> 15;
    endfunction

    function automatic logic [47:0] clamp_s48(input logic signed [95:0] v);
        if (v > 96'sd140737488355327) return 48'h7FFF_FFFF_FFFF;
        if (v < -96'sd140737488355328) return 48'h8000_0000_0000;
        return v[47:0];
    endfunction

    function automatic field_result_t predict_eval(input basis_item_t it);
        field_result_t r;
        longint acc_v, acc_gx, acc_gy, acc_gz, acc_l;
        longint dot, c, s, ws, wo, omega, w;
        logic [63:0] prod;
        logic [31:0] ang;
        logic signed [95:0] lv;
        int n;
        acc_v = 0; acc_gx = 0; acc_gy = 0; acc_gz = 0; acc_l = 0;
        n = cur_active > MAX_ENT ? MAX_ENT : cur_active;
        for (int e = 0; e < n; e++)
        begin
            w = tbl_weight[e];
            dot = longint'(tbl_dx[e]) * it.px + longint'(tbl_dy[e]) * it.py
                + longint'(tbl_dz[e]) * it.pz;
            prod = 64'(dot) * 64'(tbl_freq[e]);
            ang = prod[55:24] + {tbl_phase[e], 16'd0};
            cordic_turns(ang, c, s);
            prod = 64'(tbl_freq[e]) * 64'(TWO_PI_Q29);
            omega = longint'(prod >> 29);
            acc_v += floor_shr(w * c, 10);
            ws = floor_shr(w * s, 22);
            wo = floor_shr(ws * omega, 24);
            acc_gx -= floor_shr(wo * tbl_dx[e], 4);
            acc_gy -= floor_shr(wo * tbl_dy[e], 4);
            acc_gz -= floor_shr(wo * tbl_dz[e], 4);
            acc_l += ((w < 0 ? -w : w) * omega) >>> 4;
        end
        r.value = clamp_s48(apply_scale(acc_v));
        r.gx = clamp_s48(apply_scale(acc_gx));
        r.gy = clamp_s48(apply_scale(acc_gy));
        r.gz = clamp_s48(apply_scale(acc_gz));
        lv = apply_scale(acc_l);
        if (lv < 0) r.lip = 48'd0;
        else if (lv > 96'sd281474976710655) r.lip = {48{1'b1}};
        else r.lip = lv[47:0];
        return r;
    endfunction

    // send one transaction, update the predictor on acceptance
    task automatic send_item(input basis_item_t it);
        item_ch.valid <= 1'b1;
        item_ch.kind <= it.kind;
        item_ch.entry_index <= it.idx;
        item_ch.dir_x <= it.dx;
        item_ch.dir_y <= it.dy;
        item_ch.dir_z <= it.dz;
        item_ch.frequency <= it.freq;
        item_ch.phase <= it.phase;
        item_ch.weight <= it.weight;
        item_ch.point_x <= it.px;
        item_ch.point_y <= it.py;
        item_ch.point_z <= it.pz;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (it.kind == KIND_WRITE)
        begin
            tbl_dx[it.idx] = it.dx;
            tbl_dy[it.idx] = it.dy;
            tbl_dz[it.idx] = it.dz;
            tbl_freq[it.idx] = it.freq;
            tbl_phase[it.idx] = it.phase;
            tbl_weight[it.idx] = it.weight;
            tbl_written[it.idx] = 1'b1;
        end
        else
            expected_fields.push_back(predict_eval(it));
    endtask

    // burst sender: random gaps between bursts
    int burst_left = 0;
    task automatic send_paced(input basis_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        send_item(it);
    endtask

    task automatic idle_item();
        item_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        idle_item();
        @(posedge clk);
        while (expected_fields.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_ACTIVE_ENTRIES)
            cur_active = val & 16'h7F;
        else if (idx == CFG_NORM_SCALE)
            cur_scale = val;
        @(posedge clk);
    endtask

    function automatic basis_item_t rand_entry(input logic [5:0] idx, input int shape);
        basis_item_t it;
        it = '{default: '0};
        it.kind = KIND_WRITE;
        it.idx = idx;
        it.dx = 18'($urandom);
        it.dy = 18'($urandom);
        it.dz = 18'($urandom);
        case (shape)
            0: it.freq = $urandom;
            1: it.freq = $urandom_range(0, 32'h0400_0000);
            default: it.freq = $urandom_range(0, 32'h0010_0000);
        endcase
        it.phase = 16'($urandom);
        it.weight = 16'($urandom);
        it.px = $urandom;
        it.py = $urandom;
        it.pz = $urandom;
        return it;
    endfunction

    function automatic basis_item_t rand_point(input int shape);
        basis_item_t it;
        it = rand_entry(6'($urandom), 0);
        it.kind = KIND_EVAL;
        if (shape == 1)
        begin
            it.px = $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh4_0000;
            it.py = $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh4_0000;
            it.pz = $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh4_0000;
        end
        return it;
    endfunction

    // fill slots 0 .. n-1 so no summed entry is ever unwritten
    task automatic fill_table(input int n, input int shape);
        for (int i = 0; i < n; i++)
            send_paced(rand_entry(6'(i), shape));
    endtask

    // empty table gives zeros, scale still applied
    task automatic test_empty_table();
        write_reg(CFG_ACTIVE_ENTRIES, 16'd0);
        write_reg(CFG_NORM_SCALE, 16'hFFFF);
        for (int i = 0; i < 3; i++)
            send_item(rand_point(i));
        wait_drained();
    endtask

    // field extremes on a small table
    task automatic test_directed_extremes();
        basis_item_t it;
        it = '{default: '0};
        it.kind = KIND_WRITE;
        it.idx = 6'd0;
        it.dx = 18'sh1FFFF; it.dy = -18'sh20000; it.dz = 18'sh0;
        it.freq = 32'hFFFF_FFFF; it.phase = 16'hFFFF; it.weight = -16'sh8000;
        send_item(it);
        it.idx = 6'd1;
        it.dx = -18'sh20000; it.dy = 18'sh1FFFF; it.dz = -18'sh1;
        it.freq = 32'h0; it.phase = 16'h0; it.weight = 16'sh7FFF;
        send_item(it);
        it.idx = 6'd63;
        it.freq = 32'h0100_0000; it.phase = 16'h4000; it.weight = 16'sh1000;
        send_item(it);
        idle_item();
        write_reg(CFG_ACTIVE_ENTRIES, 16'd2);
        write_reg(CFG_NORM_SCALE, 16'hFFFF);
        it = '{default: '0};
        it.kind = KIND_EVAL;
        it.idx = 6'h3F;
        it.px = 32'sh7FFF_FFFF; it.py = -32'sh8000_0000; it.pz = -32'sh1;
        send_item(it);
        it.px = -32'sh8000_0000; it.py = 32'sh7FFF_FFFF; it.pz = 32'sh7FFF_FFFF;
        send_item(it);
        it.px = 0; it.py = 0; it.pz = 0;
        send_item(it);
        wait_drained();
        write_reg(CFG_NORM_SCALE, 16'd0);
        send_item(it);
        wait_drained();
    endtask

    // active_entries above the table size saturates; full table at max register
    task automatic test_over_active();
        fill_table(MAX_ENT, 1);
        wait_drained();
        write_reg(CFG_ACTIVE_ENTRIES, 16'd127);
        write_reg(CFG_NORM_SCALE, 16'd8192);
        for (int i = 0; i < 4; i++)
            send_item(rand_point(i & 1));
        wait_drained();
        write_reg(CFG_ACTIVE_ENTRIES, 16'd64);
        send_item(rand_point(0));
        wait_drained();
        // unknown register index does nothing
        write_reg(2'd3, 16'($urandom));
        write_reg(2'd2, 16'($urandom));
        send_item(rand_point(1));
        wait_drained();
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        write_reg(CFG_ACTIVE_ENTRIES, 16'd4);
        long_hold = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(rand_point(i & 1));
        wait_drained();
    endtask

    // random phases: mostly small tables, a few of 33 to 64 entries
    task automatic test_random_mix();
        int n, sh, left;
        left = 1250;
        while (left > 0)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 64)
                                              : $urandom_range(1, 8);
            sh = $urandom_range(0, 2);
            write_reg(CFG_ACTIVE_ENTRIES, 16'(n));
            write_reg(CFG_NORM_SCALE, ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                                                  : 16'($urandom));
            fill_table(n, sh);
            left -= n;
            for (int i = 0; i < $urandom_range(3, 12); i++)
            begin
                if ($urandom_range(0, 5) == 0)
                    send_paced(rand_entry(6'($urandom_range(n, 63)), sh));
                else
                    send_paced(rand_point($urandom_range(0, 1)));
                left--;
            end
            wait_drained();
        end
    endtask

    // receiver: random stall pattern, plus one long hold-off
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                result_ch.ready <= 1'b0;
                repeat (400)
                    @(posedge clk);
                long_hold = 1'b0;
            end
            case ($urandom_range(0, 3))
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= $urandom_range(0, 1);
                default: result_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        field_result_t exp_r;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_fields.size() == 0)
            begin
                $display("%0t: unexpected result transaction, value %h", $time,
                         result_ch.field_value);
                error_count++;
            end
            else
            begin
                exp_r = expected_fields.pop_front();
                if (result_ch.field_value !== exp_r.value)
                begin
                    $display("%0t: field_value expected %h actual %h", $time,
                             exp_r.value, result_ch.field_value);
                    error_count++;
                end
                if (result_ch.gradient_x !== exp_r.gx)
                begin
                    $display("%0t: gradient_x expected %h actual %h", $time,
                             exp_r.gx, result_ch.gradient_x);
                    error_count++;
                end
                if (result_ch.gradient_y !== exp_r.gy)
                begin
                    $display("%0t: gradient_y expected %h actual %h", $time,
                             exp_r.gy, result_ch.gradient_y);
                    error_count++;
                end
                if (result_ch.gradient_z !== exp_r.gz)
                begin
                    $display("%0t: gradient_z expected %h actual %h", $time,
                             exp_r.gz, result_ch.gradient_z);
                    error_count++;
                end
                if (result_ch.lipschitz_bound !== exp_r.lip)
                begin
                    $display("%0t: lipschitz_bound expected %h actual %h", $time,
                             exp_r.lip, result_ch.lipschitz_bound);
                    error_count++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.kind = KIND_WRITE;
        item_ch.entry_index = '0;
        item_ch.dir_x = '0;
        item_ch.dir_y = '0;
        item_ch.dir_z = '0;
        item_ch.frequency = '0;
        item_ch.phase = '0;
        item_ch.weight = '0;
        item_ch.point_x = '0;
        item_ch.point_y = '0;
        item_ch.point_z = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_ACTIVE_ENTRIES;
        cfg_ch.data = '0;
        cur_active = 0;
        cur_scale = '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_directed_extremes();
        test_over_active();
        test_backpressure();
        test_random_mix();
        idle_item();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0 && expected_fields.size() == 0)
            $display("random_fourier_feature_eval_unit verification clean");
        else
            $display("random_fourier_feature_eval_unit verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/rffe_pkg.sv
rtl/rffe_if.sv
rtl/rffe_cordic_cell.sv
rtl/rffe_datapath.sv
rtl/random_fourier_feature_eval_unit.sv
sim/tb_top.sv
